// ===== hdl/dtq_pkg.sv =====
// dtq_pkg: shared types and constants for the deadline timer queue
// no dependencies; used by dtq_front, dtq_engine and deadline_timer_queue

package dtq_pkg;

   // table geometry
   localparam int SLOTS       = 32;
   localparam int SLOT_BITS   = $clog2(SLOTS);
   localparam int TIME_BITS   = 48;
   localparam int MAX_RESULTS = 32;
   localparam int COUNT_BITS  = 6;
   localparam int HANDLE_BITS = 5;
   localparam int TAG_BITS    = 32;
   localparam int ORDER_BITS  = 32;

   // request queue between front and engine
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_BITS  = $clog2(QUEUE_DEPTH);

   // command codes
   localparam logic [1:0] CMD_ADD    = 2'd0;
   localparam logic [1:0] CMD_DELETE = 2'd1;
   localparam logic [1:0] CMD_QUERY  = 2'd2;
   localparam logic [1:0] CMD_RUN    = 2'd3;

   // status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_FULL     = 2'd1;
   localparam logic [1:0] STATUS_BAD_SLOT = 2'd2;

   // slot modes
   localparam logic [1:0] MODE_FREE  = 2'd0;
   localparam logic [1:0] MODE_ARMED = 2'd1;
   localparam logic [1:0] MODE_FIRED = 2'd2;

   // query answers
   localparam logic signed [31:0] DELAY_NONE = -32'sd1;
   localparam logic signed [31:0] DELAY_MAX  = 32'sh7FFF_FFFF;

   typedef struct packed {
      logic [1:0]             cmd;
      logic [TIME_BITS-1:0]   time_ms;
      logic [TAG_BITS-1:0]    tag;
      logic [HANDLE_BITS-1:0] handle;
   } req_type;

   typedef struct packed {
      logic [1:0]             status;
      logic [HANDLE_BITS-1:0] slot;
      logic [TAG_BITS-1:0]    fired_tag;
      logic                   fired;
      logic signed [31:0]     delay_ms;
      logic [COUNT_BITS-1:0]  fire_count;
      logic                   last;
   } rsp_type;

   // request after classification by the front
   typedef struct packed {
      logic [1:0]             cmd;
      logic [TIME_BITS-1:0]   time_ms;
      logic [TAG_BITS-1:0]    tag;
      logic [HANDLE_BITS-1:0] handle;
      logic                   handle_ok;
      logic                   needs_scan;
   } item_type;

   // handshake from the front queue to the engine
   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_out_type;

   // engine sequencer states
   typedef enum logic [4:0] {
      ST_IDLE     = 5'b00001,
      ST_DISPATCH = 5'b00010,
      ST_SCAN     = 5'b00100,
      ST_DECIDE   = 5'b01000,
      ST_EMIT     = 5'b10000
   } state_type;

endpackage

// ===== hdl/dtq_front.sv =====
// dtq_front: request intake, classification and a short request queue
// depends on dtq_pkg

module dtq_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  dtq_pkg::req_type       req_payload,
   output dtq_pkg::queue_out_type q_out,
   input  logic                   q_pop
);

   dtq_pkg::item_type               queue_ff [dtq_pkg::QUEUE_DEPTH];
   logic [dtq_pkg::QUEUE_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [dtq_pkg::QUEUE_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [dtq_pkg::QUEUE_BITS:0]    count_ff, count_in;
   dtq_pkg::item_type               item_new;
   logic                            push;
   logic                            pop;

   // classify the incoming request
   always_comb begin
      item_new.cmd        = req_payload.cmd;
      item_new.time_ms    = req_payload.time_ms;
      item_new.tag        = req_payload.tag;
      item_new.handle     = req_payload.handle;
      item_new.handle_ok  = (32'(req_payload.handle) < 32'(dtq_pkg::SLOTS));
      item_new.needs_scan = (req_payload.cmd == dtq_pkg::CMD_QUERY) ||
                            (req_payload.cmd == dtq_pkg::CMD_RUN);
   end

   assign req_ready   = (count_ff != (dtq_pkg::QUEUE_BITS+1)'(dtq_pkg::QUEUE_DEPTH));
   assign push        = req_valid && req_ready;
   assign q_out.valid = (count_ff != '0);
   assign q_out.item  = queue_ff[rd_ptr_ff];
   assign pop         = q_pop && q_out.valid;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= item_new;
      end
   end

endmodule

// ===== hdl/dtq_engine.sv =====
// dtq_engine: slot table, minimum-deadline scanner and result register
// depends on dtq_pkg

module dtq_engine (
   input  logic                   clock,
   input  logic                   reset,
   input  dtq_pkg::queue_out_type q_out,
   output logic                   q_pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output dtq_pkg::rsp_type       rsp_payload
);

   localparam int SB = dtq_pkg::SLOT_BITS;
   localparam int TB = dtq_pkg::TIME_BITS;
   localparam int CB = dtq_pkg::COUNT_BITS;
   localparam int OB = dtq_pkg::ORDER_BITS;

   // slot table
   logic [TB-1:0]                 deadline_ff [dtq_pkg::SLOTS];
   logic [dtq_pkg::TAG_BITS-1:0]  tag_ff      [dtq_pkg::SLOTS];
   logic [OB-1:0]                 order_ff    [dtq_pkg::SLOTS];
   logic [1:0]                    mode_ff     [dtq_pkg::SLOTS];
   logic [OB-1:0]                 add_cnt_ff, add_cnt_in;

   // sequencer and scan state
   dtq_pkg::state_type            state_ff, state_in;
   dtq_pkg::item_type             cmd_ff, cmd_in;
   logic [SB-1:0]                 idx_ff, idx_in;
   logic                          best_valid_ff, best_valid_in;
   logic [SB-1:0]                 best_idx_ff, best_idx_in;
   logic [TB-1:0]                 best_dl_ff, best_dl_in;
   logic [dtq_pkg::TAG_BITS-1:0]  best_tag_ff, best_tag_in;
   logic [OB-1:0]                 best_age_ff, best_age_in;
   logic [CB-1:0]                 fire_n_ff, fire_n_in;
   dtq_pkg::rsp_type              pend_ff, pend_in;
   logic                          pend_valid_ff, pend_valid_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   dtq_pkg::rsp_type              rsp_ff, rsp_in;

   // table write controls
   logic                          add_wr;
   logic [SB-1:0]                 add_idx;
   logic                          mode_wr;
   logic [SB-1:0]                 mode_idx;
   logic [1:0]                    mode_val;

   // helpers
   logic                          free_found;
   logic [SB-1:0]                 free_idx;
   logic [TB-1:0]                 cur_dl;
   logic [OB-1:0]                 cur_age;
   logic                          take;
   logic                          due;
   logic                          out_free;
   logic [TB-1:0]                 diff;
   logic [CB-1:0]                 fire_n_next;
   logic [SB-1:0]                 del_idx;
   dtq_pkg::rsp_type              blank;

   // lowest free slot
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = dtq_pkg::SLOTS - 1; i >= 0; i--) begin
         if (mode_ff[i] == dtq_pkg::MODE_FREE) begin
            free_found = 1'b1;
            free_idx   = SB'(i);
         end
      end
   end

   // one scan step: is the slot under the scan pointer the new best
   assign cur_dl  = deadline_ff[idx_ff];
   assign cur_age = add_cnt_ff - order_ff[idx_ff];
   assign take    = (mode_ff[idx_ff] == dtq_pkg::MODE_ARMED) &&
                    (!best_valid_ff || (cur_dl < best_dl_ff) ||
                     ((cur_dl == best_dl_ff) && (cur_age < best_age_ff)));

   assign due         = best_valid_ff && (best_dl_ff <= cmd_ff.time_ms);
   assign diff        = best_dl_ff - cmd_ff.time_ms;
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign fire_n_next = fire_n_ff + CB'(1);
   assign del_idx     = SB'(cmd_ff.handle);
   assign q_pop       = (state_ff == dtq_pkg::ST_IDLE) && q_out.valid;

   always_comb begin
      blank            = '0;
      blank.status     = dtq_pkg::STATUS_OK;
      blank.last       = 1'b1;
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      idx_in        = idx_ff;
      best_valid_in = best_valid_ff;
      best_idx_in   = best_idx_ff;
      best_dl_in    = best_dl_ff;
      best_tag_in   = best_tag_ff;
      best_age_in   = best_age_ff;
      fire_n_in     = fire_n_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      add_cnt_in    = add_cnt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_in        = rsp_ff;
      add_wr        = 1'b0;
      add_idx       = free_idx;
      mode_wr       = 1'b0;
      mode_idx      = free_idx;
      mode_val      = dtq_pkg::MODE_ARMED;

      case (state_ff)
         dtq_pkg::ST_IDLE: begin
            if (q_out.valid) begin
               cmd_in   = q_out.item;
               state_in = dtq_pkg::ST_DISPATCH;
            end
         end

         dtq_pkg::ST_DISPATCH: begin
            idx_in        = '0;
            best_valid_in = 1'b0;
            fire_n_in     = '0;
            pend_valid_in = 1'b0;
            pend_in       = blank;
            if (cmd_ff.needs_scan) begin
               state_in = dtq_pkg::ST_SCAN;
            end else begin
               state_in = dtq_pkg::ST_EMIT;
               case (cmd_ff.cmd)
                  dtq_pkg::CMD_ADD: begin
                     if (free_found) begin
                        add_wr       = 1'b1;
                        mode_wr      = 1'b1;
                        add_cnt_in   = add_cnt_ff + OB'(1);
                        pend_in.slot = dtq_pkg::HANDLE_BITS'(free_idx);
                     end else begin
                        pend_in.status = dtq_pkg::STATUS_FULL;
                     end
                  end
                  dtq_pkg::CMD_DELETE: begin
                     pend_in.slot = cmd_ff.handle;
                     if (!cmd_ff.handle_ok || mode_ff[del_idx] == dtq_pkg::MODE_FREE) begin
                        pend_in.status = dtq_pkg::STATUS_BAD_SLOT;
                     end else begin
                        mode_wr  = 1'b1;
                        mode_idx = del_idx;
                        mode_val = dtq_pkg::MODE_FREE;
                     end
                  end
                  default: begin
                     pend_in = blank;
                  end
               endcase
            end
         end

         dtq_pkg::ST_SCAN: begin
            if (take) begin
               best_valid_in = 1'b1;
               best_idx_in   = idx_ff;
               best_dl_in    = cur_dl;
               best_tag_in   = tag_ff[idx_ff];
               best_age_in   = cur_age;
            end
            if (idx_ff == SB'(dtq_pkg::SLOTS - 1)) begin
               state_in = dtq_pkg::ST_DECIDE;
            end else begin
               idx_in = idx_ff + SB'(1);
            end
         end

         dtq_pkg::ST_DECIDE: begin
            if (cmd_ff.cmd == dtq_pkg::CMD_QUERY) begin
               pend_in = blank;
               if (!best_valid_ff) begin
                  pend_in.delay_ms = dtq_pkg::DELAY_NONE;
               end else if (due) begin
                  pend_in.delay_ms = '0;
               end else if (diff > TB'(dtq_pkg::DELAY_MAX)) begin
                  pend_in.delay_ms = dtq_pkg::DELAY_MAX;
               end else begin
                  pend_in.delay_ms = 32'(diff);
               end
               state_in = dtq_pkg::ST_EMIT;
            end else if (due) begin
               // fire the best slot, releasing the one held back before it
               if (!pend_valid_ff || out_free) begin
                  if (pend_valid_ff) begin
                     rsp_in       = pend_ff;
                     rsp_valid_in = 1'b1;
                  end
                  mode_wr           = 1'b1;
                  mode_idx          = best_idx_ff;
                  mode_val          = dtq_pkg::MODE_FIRED;
                  pend_in           = '0;
                  pend_in.status    = dtq_pkg::STATUS_OK;
                  pend_in.slot      = dtq_pkg::HANDLE_BITS'(best_idx_ff);
                  pend_in.fired_tag = best_tag_ff;
                  pend_in.fired     = 1'b1;
                  fire_n_in         = fire_n_next;
                  if (fire_n_next == CB'(dtq_pkg::MAX_RESULTS)) begin
                     pend_in.last       = 1'b1;
                     pend_in.fire_count = fire_n_next;
                     state_in           = dtq_pkg::ST_EMIT;
                  end else begin
                     pend_valid_in = 1'b1;
                     idx_in        = '0;
                     best_valid_in = 1'b0;
                     state_in      = dtq_pkg::ST_SCAN;
                  end
               end
            end else begin
               // nothing more due: close the run
               if (pend_valid_ff) begin
                  pend_in.last       = 1'b1;
                  pend_in.fire_count = fire_n_ff;
               end else begin
                  pend_in = blank;
               end
               state_in = dtq_pkg::ST_EMIT;
            end
         end

         dtq_pkg::ST_EMIT: begin
            if (out_free) begin
               rsp_in        = pend_ff;
               rsp_valid_in  = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = dtq_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = dtq_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= dtq_pkg::ST_IDLE;
         best_valid_ff <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         add_cnt_ff    <= '0;
         fire_n_ff     <= '0;
         idx_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         best_valid_ff <= best_valid_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         add_cnt_ff    <= add_cnt_in;
         fire_n_ff     <= fire_n_in;
         idx_ff        <= idx_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      best_idx_ff <= best_idx_in;
      best_dl_ff  <= best_dl_in;
      best_tag_ff <= best_tag_in;
      best_age_ff <= best_age_in;
      pend_ff     <= pend_in;
      rsp_ff      <= rsp_in;
   end

   // slot modes, all free after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < dtq_pkg::SLOTS; i++) begin
            mode_ff[i] <= dtq_pkg::MODE_FREE;
         end
      end else if (mode_wr) begin
         mode_ff[mode_idx] <= mode_val;
      end
   end

   // slot contents, only read while the slot is armed
   always_ff @(posedge clock) begin
      if (add_wr) begin
         deadline_ff[add_idx] <= cmd_ff.time_ms;
         tag_ff[add_idx]      <= cmd_ff.tag;
         order_ff[add_idx]    <= add_cnt_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== hdl/deadline_timer_queue.sv =====
// deadline_timer_queue: top level of the timer slot table
// depends on dtq_pkg, dtq_front and dtq_engine

// A table of 32 timer slots. Add arms the lowest free slot and returns it as a
// handle, delete frees an armed or fired slot, query reports the time left to
// the earliest armed deadline, and run fires every due slot in deadline order
// (newest first among equal deadlines), one response per fired slot with the
// count on the last. Requests enter a four-deep queue, so the request side
// keeps accepting until it is full while the engine works and a response waits
// in the output register. Query and each fired slot of a run cost one pass of
// the scanner over the slot table; a run stops at the cap of 32 fired slots.
// A single scan pointer walks the table; a fired response still held while
// rsp_ready is low holds back the next firing and adds its wait.

module deadline_timer_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  dtq_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output dtq_pkg::rsp_type rsp_payload
);

   dtq_pkg::queue_out_type q_out;
   logic                   q_pop;

   // request intake and queue
   dtq_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .q_out       (q_out),
      .q_pop       (q_pop)
   );

   // slot table and scanner
   dtq_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .q_out       (q_out),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== verif/dtq_tb_pkg.sv =====
// dtq_tb_pkg: slot table checker for the deadline timer queue testbench
// depends on dtq_pkg; used by tb
`timescale 1ns / 100ps

package dtq_tb_pkg;

   import dtq_pkg::*;

   class slot_table_checker;

      // mirror of the slot table
      logic [TIME_BITS-1:0]  deadline [SLOTS];
      logic [TAG_BITS-1:0]   tag_word [SLOTS];
      logic [1:0]            mode     [SLOTS];
      logic [ORDER_BITS-1:0] order    [SLOTS];
      logic [ORDER_BITS-1:0] adds;

      // responses still owed by the block, oldest first
      rsp_type pending_results [$];
      int      errors;
      int      responses_seen;

      function new();
         for (int i = 0; i < SLOTS; i++) begin
            deadline[i] = '0;
            tag_word[i] = '0;
            mode[i]     = MODE_FREE;
            order[i]    = '0;
         end
         adds           = '0;
         errors         = 0;
         responses_seen = 0;
      endfunction

      function int pending();
         return pending_results.size();
      endfunction

      // earliest armed slot, newest add wins a tie, -1 when none armed
      function int earliest_armed();
         int best;
         logic [ORDER_BITS-1:0] age_i;
         logic [ORDER_BITS-1:0] age_b;
         best = -1;
         for (int i = 0; i < SLOTS; i++) begin
            if (mode[i] != MODE_ARMED) continue;
            if (best < 0 || deadline[i] < deadline[best]) begin
               best = i;
            end else if (deadline[i] == deadline[best]) begin
               age_i = adds - order[i];
               age_b = adds - order[best];
               if (age_i < age_b) best = i;
            end
         end
         return best;
      endfunction

      // update the table for an accepted request and queue its responses
      function void note_request(req_type r);
         rsp_type e;
         rsp_type held;
         int      slot_idx;
         int      n;
         logic [TIME_BITS:0] gap;
         e = '0;
         e.last = 1'b1;
         case (r.cmd)
            CMD_ADD: begin
               slot_idx = -1;
               for (int i = 0; i < SLOTS; i++) begin
                  if (slot_idx < 0 && mode[i] == MODE_FREE) slot_idx = i;
               end
               if (slot_idx < 0) begin
                  e.status = STATUS_FULL;
               end else begin
                  deadline[slot_idx] = r.time_ms;
                  tag_word[slot_idx] = r.tag;
                  mode[slot_idx]     = MODE_ARMED;
                  order[slot_idx]    = adds;
                  adds               = adds + 1'b1;
                  e.slot             = HANDLE_BITS'(slot_idx);
               end
               pending_results.push_back(e);
            end
            CMD_DELETE: begin
               e.slot = r.handle;
               if (int'(r.handle) >= SLOTS || mode[r.handle] == MODE_FREE) begin
                  e.status = STATUS_BAD_SLOT;
               end else begin
                  mode[r.handle] = MODE_FREE;
               end
               pending_results.push_back(e);
            end
            CMD_QUERY: begin
               slot_idx = earliest_armed();
               if (slot_idx < 0) begin
                  e.delay_ms = DELAY_NONE;
               end else if (deadline[slot_idx] <= r.time_ms) begin
                  e.delay_ms = '0;
               end else begin
                  gap = {1'b0, deadline[slot_idx]} - {1'b0, r.time_ms};
                  if (gap > (TIME_BITS + 1)'(DELAY_MAX)) e.delay_ms = DELAY_MAX;
                  else e.delay_ms = gap[31:0];
               end
               pending_results.push_back(e);
            end
            default: begin
               // run: one response per fired slot, count on the last one
               n    = 0;
               held = '0;
               while (n < MAX_RESULTS) begin
                  slot_idx = earliest_armed();
                  if (slot_idx < 0 || deadline[slot_idx] > r.time_ms) break;
                  mode[slot_idx] = MODE_FIRED;
                  if (n > 0) pending_results.push_back(held);
                  held           = '0;
                  held.slot      = HANDLE_BITS'(slot_idx);
                  held.fired_tag = tag_word[slot_idx];
                  held.fired     = 1'b1;
                  n++;
               end
               if (n == 0) begin
                  pending_results.push_back(e);
               end else begin
                  held.fire_count = COUNT_BITS'(n);
                  held.last       = 1'b1;
                  pending_results.push_back(held);
               end
            end
         endcase
      endfunction

      task report_mismatch(string msg);
         errors++;
         $display("[%0t] response %0d: %s", $time, responses_seen, msg);
      endtask

      // compare one accepted response with the oldest expectation
      task check_response(rsp_type got);
         rsp_type want;
         responses_seen++;
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("unexpected response %p", got));
         end else begin
            want = pending_results.pop_front();
            if (got.status !== want.status)
               report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
            if (got.slot !== want.slot)
               report_mismatch($sformatf("slot %0d, expected %0d", got.slot, want.slot));
            if (got.fired_tag !== want.fired_tag)
               report_mismatch($sformatf("fired_tag %h, expected %h",
                                         got.fired_tag, want.fired_tag));
            if (got.fired !== want.fired)
               report_mismatch($sformatf("fired %b, expected %b", got.fired, want.fired));
            if (got.delay_ms !== want.delay_ms)
               report_mismatch($sformatf("delay_ms %0d, expected %0d",
                                         got.delay_ms, want.delay_ms));
            if (got.fire_count !== want.fire_count)
               report_mismatch($sformatf("fire_count %0d, expected %0d",
                                         got.fire_count, want.fire_count));
            if (got.last !== want.last)
               report_mismatch($sformatf("last %b, expected %b", got.last, want.last));
         end
      endtask

   endclass

endpackage

// ===== verif/tb.sv =====
// tb: top of the deadline timer queue testbench, drives requests and checks responses
// depends on dtq_pkg, dtq_tb_pkg and deadline_timer_queue
`timescale 1ns / 100ps

module tb;

   import dtq_pkg::*;
   import dtq_tb_pkg::*;

   localparam int CYCLE_LIMIT  = 3_000_000;
   localparam int DRAIN_CYCLES = 4 * (SLOTS + 1);
   localparam logic [TIME_BITS-1:0] TIME_END = '1;

   logic    clock;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready   = 1'b0;
   rsp_type rsp_payload;

   int send_idle_pct = 33;
   int recv_idle_pct = 80;
   int cycle_count   = 0;
   logic [TIME_BITS-1:0] now_ms;

   slot_table_checker table_check = new();

   deadline_timer_queue u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // response side: check on handshake, stall at random
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) table_check.check_response(rsp_payload);
      rsp_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic req_type make_request(logic [1:0] cmd, logic [TIME_BITS-1:0] t,
                                            logic [TAG_BITS-1:0] tag,
                                            logic [HANDLE_BITS-1:0] handle);
      req_type r;
      r.cmd     = cmd;
      r.time_ms = t;
      r.tag     = tag;
      r.handle  = handle;
      return r;
   endfunction

   // present one request, hold it until accepted
   task automatic send_request(req_type r);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (!req_ready);
      table_check.note_request(r);
   endtask

   // directed: empty table, bad handles, ties, saturation, due and fired slots
   task automatic run_directed();
      send_request(make_request(CMD_QUERY,  '0,           '0,           5'd0));
      send_request(make_request(CMD_RUN,    TIME_END,     '0,           5'd31));
      send_request(make_request(CMD_DELETE, '0,           '0,           5'd0));
      send_request(make_request(CMD_DELETE, TIME_END,     '1,           5'd31));
      send_request(make_request(CMD_ADD,    48'd100,      32'h0,        5'd0));
      send_request(make_request(CMD_ADD,    48'd100,      32'hFFFF_FFFF, 5'd31));
      send_request(make_request(CMD_ADD,    48'd50,       32'hA5A5_5A5A, 5'd10));
      send_request(make_request(CMD_ADD,    TIME_END,     32'h1234_5678, 5'd21));
      send_request(make_request(CMD_ADD,    '0,           32'h5A5A_A5A5, 5'd0));
      send_request(make_request(CMD_QUERY,  48'd10,       '0,           5'd0));
      send_request(make_request(CMD_DELETE, '0,           '0,           5'd4));
      send_request(make_request(CMD_QUERY,  48'd10,       '1,           5'd31));
      send_request(make_request(CMD_QUERY,  '0,           '0,           5'd0));
      send_request(make_request(CMD_QUERY,  TIME_END,     '0,           5'd0));
      send_request(make_request(CMD_RUN,    48'd49,       '0,           5'd0));
      send_request(make_request(CMD_RUN,    48'd100,      '0,           5'd0));
      send_request(make_request(CMD_DELETE, '0,           '0,           5'd1));
      send_request(make_request(CMD_DELETE, '0,           '0,           5'd1));
      send_request(make_request(CMD_QUERY,  '0,           '0,           5'd0));
      send_request(make_request(CMD_RUN,    TIME_END - 1'b1, '0,        5'd0));
      send_request(make_request(CMD_RUN,    TIME_END,     '0,           5'd0));
      send_request(make_request(CMD_QUERY,  48'd5,        '0,           5'd0));
      send_request(make_request(CMD_ADD,    48'd7,        32'hDEAD_BEEF, 5'd3));
   endtask

   // random: alternating fill and drain spells around an advancing clock time
   task automatic random_requests(int count);
      req_type r;
      int      pick;
      bit      filling;
      int      occupied [$];
      filling = 1'b1;
      for (int k = 0; k < count; k++) begin
         if (k % 40 == 39) filling = !filling;
         r.cmd     = CMD_QUERY;
         r.time_ms = {16'($urandom), $urandom};
         r.tag     = $urandom;
         r.handle  = HANDLE_BITS'($urandom_range(31, 0));
         pick      = $urandom_range(99, 0);
         if (filling) begin
            if (pick < 70)      r.cmd = CMD_ADD;
            else if (pick < 75) r.cmd = CMD_DELETE;
            else if (pick < 85) r.cmd = CMD_QUERY;
            else                r.cmd = CMD_RUN;
         end else begin
            if (pick < 25)      r.cmd = CMD_ADD;
            else if (pick < 55) r.cmd = CMD_DELETE;
            else if (pick < 70) r.cmd = CMD_QUERY;
            else                r.cmd = CMD_RUN;
         end
         case (r.cmd)
            CMD_ADD: begin
               pick = $urandom_range(9, 0);
               if (pick == 1) r.time_ms = $urandom_range(1, 0) ? TIME_END : '0;
               else if (pick > 1) r.time_ms = now_ms + TIME_BITS'($urandom_range(20, 0));
            end
            CMD_DELETE: begin
               occupied.delete();
               for (int i = 0; i < SLOTS; i++)
                  if (table_check.mode[i] != MODE_FREE) occupied.push_back(i);
               if (occupied.size() > 0 && $urandom_range(99, 0) < 85)
                  r.handle = HANDLE_BITS'(occupied[$urandom_range(occupied.size() - 1, 0)]);
            end
            CMD_QUERY: begin
               if ($urandom_range(9, 0) < 7)
                  r.time_ms = now_ms + TIME_BITS'($urandom_range(40, 0));
            end
            default: begin
               pick = $urandom_range(24, 0);
               if (pick == 0) begin
                  r.time_ms = TIME_END;
               end else if (pick > 1) begin
                  now_ms    = now_ms + TIME_BITS'($urandom_range(25, 0));
                  r.time_ms = now_ms;
               end
            end
         endcase
         send_request(r);
      end
   endtask

   // main sequence
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      now_ms = TIME_BITS'($urandom_range(1_000_000, 1000));
      random_requests(125);
      send_idle_pct = 80;
      recv_idle_pct = 33;
      random_requests(125);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_requests(120);
      req_valid <= 1'b0;
      while (table_check.pending() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (table_check.errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
